### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

### src/efit_pkg.sv
// ----------------------------------------------------------------------------
// efit_pkg
// Types and constants shared by the frame idle-time tracker modules.
// ----------------------------------------------------------------------------
package efit_pkg;

  localparam int ASIC_COUNT = 512;
  localparam int CH_DEPTH   = ASIC_COUNT * 64;
  localparam int TAC_DEPTH  = ASIC_COUNT * 256;
  localparam int CIDX_W     = $clog2(CH_DEPTH);
  localparam int TIDX_W     = $clog2(TAC_DEPTH);

  localparam int WORD_W   = 64;
  localparam int FRAME_W  = 36;
  localparam int WORDS_W  = 15;
  localparam int CNT_W    = 16;
  localparam int CHIP_W   = 9;
  localparam int CH_W     = 6;
  localparam int TAC_W    = 2;
  localparam int COARSE_W = 10;
  localparam int TIME_W   = FRAME_W + COARSE_W;
  localparam int IDLE_W   = TIME_W + 1;
  localparam int MASK_W   = 32;

  localparam int OUT_FIELDS_W = FRAME_W + 1 + CHIP_W + CH_W + TAC_W + TIME_W + 2 * IDLE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_ACCEPT   = 2'd0,
    KIND_MISMATCH = 2'd1,
    KIND_EVENT    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_COUNT  = 3'b010,
    PH_EVENTS = 3'b100
  } phase_t;

  // Decoded item handed from the parser to the idle-time stage.
  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [FRAME_W-1:0]  frame;
    logic                lost;
    logic [CHIP_W-1:0]   chip;
    logic [CH_W-1:0]     ch;
    logic [TAC_W-1:0]    tac;
    logic [TIME_W-1:0]   t;
    logic                last;
    logic [CIDX_W-1:0]   cidx;
    logic [TIDX_W-1:0]   tidx;
  } item_t;

  // Write-back of an event time into both last-time stores.
  typedef struct packed {
    logic              we;
    logic [CIDX_W-1:0] cidx;
    logic [TIDX_W-1:0] tidx;
    logic [TIME_W-1:0] t;
  } wr_t;

endpackage

### src/event_frame_idle_time_tracker_unit.sv
// ----------------------------------------------------------------------------
// event_frame_idle_time_tracker_unit
// Frame word parser with per-channel and per-converter idle-time tracking.
// ----------------------------------------------------------------------------
// Input stream: one 64-bit frame word per transfer on in_tdata; in_tuser is set
// on the header word that opens a frame. Header and count words decide whether
// the frame is taken; event words of a taken frame are decoded.
// Result stream: one transfer for each count word (tuser 0 accepted, 1 size
// mismatch) and one for each event word in the frame (tuser 2); out_tlast marks
// the final event of a frame. Header words and words outside a frame give none.
// Configuration: cfg_wr_en writes the 32-bit front-end format mask.
// Throughput is one word per cycle while in_tready is high. A result is presented
// on out_tvalid from the output register: the last-time memories are read on the
// accepting edge, and the difference is registered as the idle stage moves on.
// Back-to-back events that hit the same store entry get the newer time
// forwarded from the write-back stage.
// After reset a clearing pass zeroes both memories, one address per cycle over
// the 131072 converter entries; in_tready stays low until it ends.
// When out_tready is low the result waits in the output register; one more
// word that gives a result is still taken into the idle stage, then in_tready
// drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module event_frame_idle_time_tracker_unit import efit_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [MASK_W-1:0]     cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [WORD_W-1:0]     in_tdata,   // word[63:0]
  input  logic                  in_tuser,   // start_of_frame
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // frame_number[35:0], frame_lost[36], chip_index[45:37], channel[51:46],
  // tac[53:52], event_time[99:54], channel_idle[146:100], tac_idle[193:147]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,  // kind[1:0]
  output logic                  out_tlast   // last_in_frame
);

  item_t             item;
  wr_t               wr;
  logic              in_accept;
  logic              s1_free;
  logic              rd_en;
  logic              clr_r;
  logic [TIDX_W-1:0] clr_cnt_r;
  logic              ch_we, tac_we;
  logic [CIDX_W-1:0] ch_waddr;
  logic [TIDX_W-1:0] tac_waddr;
  logic [TIME_W-1:0] mem_wdata;
  logic [TIME_W-1:0] ch_q, tac_q;

  assign in_tready = s1_free && !clr_r;
  assign in_accept = in_tvalid && in_tready;
  assign rd_en     = in_accept && item.valid && (item.kind == KIND_EVENT);

  // Clearing sweep after reset; the channel store sees each entry four times.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + TIDX_W'(1);
      if (clr_cnt_r == TIDX_W'(TAC_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign ch_we     = clr_r || wr.we;
  assign tac_we    = clr_r || wr.we;
  assign ch_waddr  = clr_r ? clr_cnt_r[TIDX_W-1:2] : wr.cidx;
  assign tac_waddr = clr_r ? clr_cnt_r : wr.tidx;
  assign mem_wdata = clr_r ? '0 : wr.t;

  efit_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_accept   (in_accept),
    .in_word     (in_tdata),
    .in_sof      (in_tuser),
    .item        (item)
  );

  efit_ram #(
    .DEPTH (CH_DEPTH),
    .WIDTH (TIME_W)
  ) u_ch_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (item.cidx),
    .rdata (ch_q)
  );

  efit_ram #(
    .DEPTH (TAC_DEPTH),
    .WIDTH (TIME_W)
  ) u_tac_ram (
    .clk   (clk),
    .we    (tac_we),
    .waddr (tac_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (item.tidx),
    .rdata (tac_q)
  );

  efit_idle u_idle (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .item       (item),
    .ch_q       (ch_q),
    .tac_q      (tac_q),
    .s1_free    (s1_free),
    .wr         (wr),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `ASSERT_IMPL(a_no_input_while_clearing, clk, rst_n, clr_r, !in_tready)
  `ASSERT_IMPL(a_no_writeback_while_clearing, clk, rst_n, clr_r, !wr.we)

endmodule

### src/efit_ram.sv
// ----------------------------------------------------------------------------
// efit_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module efit_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/efit_parse.sv
// ----------------------------------------------------------------------------
// efit_parse
// Frame state tracking and event word decode; issues the store read address.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efit_parse import efit_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [MASK_W-1:0] cfg_wr_data,
  input  logic              in_accept,
  input  logic [WORD_W-1:0] in_word,
  input  logic              in_sof,
  output item_t             item
);

  logic [MASK_W-1:0]  fe_mask_r;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [WORDS_W-1:0] words_r, words_nxt;
  logic [WORDS_W-1:0] pos_r, pos_nxt;
  phase_t             phase_r, phase_nxt;

  logic [CNT_W:0]     cnt_sum;
  logic               size_match;
  logic [WORDS_W:0]   pos_plus;
  logic [CHIP_W-1:0]  chip;
  logic               second_fmt;
  logic [CH_W-1:0]    ch;
  logic [TAC_W-1:0]   tac;

  // Chip index folds slave bit, port nibble and chip nibble of the id field.
  assign chip       = {in_word[54], in_word[62:59], in_word[51:48]};
  assign second_fmt = fe_mask_r[chip[CHIP_W-1:4]];
  assign ch         = second_fmt ? in_word[47:42] : in_word[7:2];
  assign tac        = second_fmt ? '0 : in_word[1:0];
  assign cnt_sum    = {1'b0, in_word[CNT_W-1:0]} + (CNT_W+1)'(2);
  assign size_match = ({{(CNT_W+1-WORDS_W){1'b0}}, words_r} == cnt_sum);
  assign pos_plus   = {1'b0, pos_r} + (WORDS_W+1)'(1);

  always_comb begin
    frame_nxt = frame_r;
    words_nxt = words_r;
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    item      = '0;
    if (in_accept) begin
      if (in_sof) begin
        frame_nxt = in_word[FRAME_W-1:0];
        words_nxt = in_word[FRAME_W+WORDS_W-1:FRAME_W];
        pos_nxt   = WORDS_W'(1);
        phase_nxt = PH_COUNT;
      end else begin
        case (phase_r)
          PH_COUNT: begin
            item.valid = 1'b1;
            item.frame = frame_r;
            item.lost  = in_word[CNT_W];
            if (size_match) begin
              item.kind = KIND_ACCEPT;
              pos_nxt   = WORDS_W'(2);
              phase_nxt = (words_r > WORDS_W'(2)) ? PH_EVENTS : PH_IDLE;
            end else begin
              item.kind = KIND_MISMATCH;
              phase_nxt = PH_IDLE;
            end
          end
          PH_EVENTS: begin
            if (pos_r >= words_r) begin
              phase_nxt = PH_IDLE;
            end else begin
              item.valid = 1'b1;
              item.kind  = KIND_EVENT;
              item.frame = frame_r;
              item.chip  = chip;
              item.ch    = ch;
              item.tac   = tac;
              // Frame times 1024 leaves the low ten bits free for the coarse time.
              item.t     = second_fmt ? {frame_r, COARSE_W'(0)}
                                      : {frame_r, in_word[47:38]};
              item.last  = (pos_plus == {1'b0, words_r});
              item.cidx  = CIDX_W'({chip, ch});
              item.tidx  = {CIDX_W'({chip, ch}), tac};
              pos_nxt    = pos_plus[WORDS_W-1:0];
              if (pos_plus >= {1'b0, words_r}) begin
                phase_nxt = PH_IDLE;
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_mask_r <= '0;
      frame_r   <= '0;
      words_r   <= '0;
      pos_r     <= '0;
      phase_r   <= PH_IDLE;
    end else begin
      if (cfg_wr_en) begin
        fe_mask_r <= cfg_wr_data;
      end
      frame_r <= frame_nxt;
      words_r <= words_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
    end
  end

  `ASSERT_IMPL(a_pos_in_frame, clk, rst_n, phase_r == PH_EVENTS, pos_r < words_r)
  `ASSERT_IMPL(a_event_only_in_frame, clk, rst_n, item.valid && item.kind == KIND_EVENT, phase_r == PH_EVENTS)

endmodule

### src/efit_idle.sv
// ----------------------------------------------------------------------------
// efit_idle
// Idle-time stage: read data merge with forwarding, store write-back and the
// output register of the result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efit_idle import efit_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  item_t                 item,
  input  logic [TIME_W-1:0]     ch_q,
  input  logic [TIME_W-1:0]     tac_q,
  output logic                  s1_free,
  output wr_t                   wr,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  item_t               s1_r;
  logic                s1_v_r;
  logic                s1_go;
  logic                s1_event;
  logic                ch_fwd_r, tac_fwd_r;
  logic                ch_fwd_nxt, tac_fwd_nxt;
  logic [TIME_W-1:0]   fwd_t_r;
  logic [TIME_W-1:0]   ch_prev, tac_prev;
  logic [IDLE_W-1:0]   ch_idle, tac_idle;
  logic                out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]          out_kind_r;
  logic                out_last_r;

  assign s1_event = (s1_r.kind == KIND_EVENT);
  assign s1_go    = s1_v_r && (!out_v_r || out_tready);
  assign s1_free  = !s1_v_r || s1_go;

  // The event leaving this stage writes its time on the same edge at which a
  // newly accepted event reads the stores, so a matching address is forwarded.
  assign ch_fwd_nxt  = in_accept && item.valid && (item.kind == KIND_EVENT) &&
                       s1_go && s1_event && (s1_r.cidx == item.cidx);
  assign tac_fwd_nxt = ch_fwd_nxt && (s1_r.tidx == item.tidx);

  assign ch_prev  = ch_fwd_r  ? fwd_t_r : ch_q;
  assign tac_prev = tac_fwd_r ? fwd_t_r : tac_q;
  assign ch_idle  = s1_event ? ({1'b0, s1_r.t} - {1'b0, ch_prev}) : '0;
  assign tac_idle = s1_event ? ({1'b0, s1_r.t} - {1'b0, tac_prev}) : '0;

  assign wr.we   = s1_go && s1_event;
  assign wr.cidx = s1_r.cidx;
  assign wr.tidx = s1_r.tidx;
  assign wr.t    = s1_r.t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      ch_fwd_r  <= 1'b0;
      tac_fwd_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (in_accept && item.valid) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (in_accept || s1_go) begin
        ch_fwd_r  <= ch_fwd_nxt;
        tac_fwd_r <= tac_fwd_nxt;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && item.valid) begin
      s1_r    <= item;
      fwd_t_r <= s1_r.t;
    end
    if (s1_go) begin
      out_data_r <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, tac_idle, ch_idle, s1_r.t,
                     s1_r.tac, s1_r.ch, s1_r.chip, s1_r.lost, s1_r.frame};
      out_kind_r <= s1_r.kind;
      out_last_r <= s1_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `ASSERT_IMPL(a_tac_fwd_implies_ch_fwd, clk, rst_n, tac_fwd_r, ch_fwd_r)
  `ASSERT_IMPL(a_fwd_only_for_event, clk, rst_n, ch_fwd_r, s1_v_r && s1_event)
  `ASSERT_NEXT(a_stage_drains, clk, rst_n, s1_go && !(in_accept && item.valid), !s1_v_r)

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame idle-time tracker. Frames of header, count
// and event words are streamed in under several front-end format masks. A
// scoreboard keeps its own copy of the frame state and of both last-time
// stores, predicts every result transfer and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import efit_pkg::*;

  localparam int CYCLE_LIMIT = 900000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS = 225;

  typedef enum int {
    FLAW_NONE,
    FLAW_MISMATCH,
    FLAW_BIGCOUNT,
    FLAW_CUT,
    FLAW_EXTRA,
    FLAW_NOCOUNT
  } flaw_t;

  // Same order as out_tdata, highest field first.
  typedef struct packed {
    logic [IDLE_W-1:0]  tac_idle;
    logic [IDLE_W-1:0]  chan_idle;
    logic [TIME_W-1:0]  evt_time;
    logic [TAC_W-1:0]   tac;
    logic [CH_W-1:0]    channel;
    logic [CHIP_W-1:0]  chip;
    logic               lost;
    logic [FRAME_W-1:0] frame;
  } payload_t;

  typedef struct packed {
    kind_t    kind;
    payload_t p;
    logic     last;
  } result_t;

  class frame_scoreboard;
    bit [MASK_W-1:0]  fe_mask;
    bit [TIME_W-1:0]  chan_last [CH_DEPTH];
    bit [TIME_W-1:0]  tac_last [TAC_DEPTH];
    bit [FRAME_W-1:0] cur_frame;
    int unsigned      frame_words;
    int unsigned      word_pos;
    phase_t           phase;
    result_t          expected_q[$];
    int               errors;
    int               n_accept;
    int               n_skip;
    int               n_event;

    function new();
      phase = PH_IDLE;
    endfunction

    function void set_mask(bit [MASK_W-1:0] v);
      fe_mask = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the frame state by one accepted input word.
    function void note_word(bit [WORD_W-1:0] w, bit sof);
      result_t          r;
      bit [CHIP_W-1:0]  chip;
      bit [CH_W-1:0]    ch;
      bit [TAC_W-1:0]   tac;
      bit [TIME_W-1:0]  t;
      bit [CIDX_W-1:0]  cidx;
      bit [TIDX_W-1:0]  tidx;
      r = '0;
      if (sof) begin
        cur_frame = w[35:0];
        frame_words = w[50:36];
        word_pos = 1;
        phase = PH_COUNT;
      end else if (phase == PH_COUNT) begin
        r.p.frame = cur_frame;
        r.p.lost = w[16];
        // The sum is compared at full width, so a huge count never matches.
        if (frame_words == w[15:0] + 32'd2) begin
          r.kind = KIND_ACCEPT;
          word_pos = 2;
          phase = (frame_words > 2) ? PH_EVENTS : PH_IDLE;
        end else begin
          r.kind = KIND_MISMATCH;
          phase = PH_IDLE;
        end
        expected_q.push_back(r);
      end else if (phase != PH_EVENTS || word_pos >= frame_words) begin
        phase = PH_IDLE;
      end else begin
        chip = {w[54], w[62:59], w[51:48]};
        t = {cur_frame, 10'd0};
        if (fe_mask[chip[8:4]]) begin
          ch = w[47:42];
          tac = '0;
        end else begin
          ch = w[7:2];
          tac = w[1:0];
          t = t + w[47:38];
        end
        cidx = {chip, ch};
        tidx = {chip, ch, tac};
        r.kind = KIND_EVENT;
        r.p.frame = cur_frame;
        r.p.chip = chip;
        r.p.channel = ch;
        r.p.tac = tac;
        r.p.evt_time = t;
        r.p.chan_idle = {1'b0, t} - {1'b0, chan_last[cidx]};
        r.p.tac_idle = {1'b0, t} - {1'b0, tac_last[tidx]};
        r.last = (word_pos + 1 == frame_words);
        chan_last[cidx] = t;
        tac_last[tidx] = t;
        expected_q.push_back(r);
        word_pos++;
        if (word_pos >= frame_words) phase = PH_IDLE;
      end
    endfunction

    task report(string what);
      $display("[%0t] check failed: %s", $time, what);
      errors++;
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] exp);
      if (got !== exp) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d, logic [1:0] u, logic l);
      result_t  e;
      payload_t g;
      if (expected_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        e = expected_q.pop_front();
        g = d[OUT_FIELDS_W-1:0];
        check_field("kind", u, e.kind);
        check_field("frame_number", g.frame, e.p.frame);
        check_field("frame_lost", g.lost, e.p.lost);
        check_field("chip_index", g.chip, e.p.chip);
        check_field("channel", g.channel, e.p.channel);
        check_field("tac", g.tac, e.p.tac);
        check_field("event_time", g.evt_time, e.p.evt_time);
        check_field("channel_idle", g.chan_idle, e.p.chan_idle);
        check_field("tac_idle", g.tac_idle, e.p.tac_idle);
        check_field("last_in_frame", l, e.last);
        case (e.kind)
          KIND_ACCEPT:   n_accept++;
          KIND_MISMATCH: n_skip++;
          default:       n_event++;
        endcase
      end
    endtask

    task drain_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d expected results never arrived", expected_q.size()));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [MASK_W-1:0]     cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  frame_scoreboard sb;
  int              words_sent;
  int              cycle_count;
  int              mask_count;
  bit              idle_on;
  bit [FRAME_W-1:0] frame_base;
  bit [WORD_W-1:0] prev_evt;

  event_frame_idle_time_tracker_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stall bursts while idling is enabled.
  always begin
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[event_frame_idle_time_tracker_unit] ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_word(input bit [WORD_W-1:0] w, input bit sof);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tuser <= sof;
    do @(posedge clk); while (!in_tready);
    sb.note_word(w, sof);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_mask(input bit [MASK_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_mask(v);
    mask_count++;
  endtask

  // Hold the input idle, wait for all expected results, then let the pipe drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Most events land on a few chips and channels so the stores are revisited.
  function automatic bit [WORD_W-1:0] make_event();
    bit [WORD_W-1:0] w;
    if ($urandom_range(0, 9) == 0) return prev_evt;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 7) begin
      w[51:48] = $urandom_range(0, 1);
      w[62:59] = $urandom_range(0, 1);
      w[7:2] = $urandom_range(0, 3);
      w[47:42] = $urandom_range(0, 3);
    end
    prev_evt = w;
    return w;
  endfunction

  function automatic bit [FRAME_W-1:0] pick_frame();
    bit [FRAME_W-1:0] f;
    f = {$urandom, $urandom};
    if ($urandom_range(0, 4) == 0) return f;
    // Drifts mostly forward, sometimes back, giving idle times of both signs.
    frame_base = frame_base + $urandom_range(0, 3) - 1;
    return frame_base + $urandom_range(0, 2);
  endfunction

  task automatic send_frame(input bit [FRAME_W-1:0] fno, input int nev, input flaw_t flaw);
    bit [WORDS_W-1:0] size;
    bit [CNT_W-1:0]   cnt;
    bit [WORD_W-1:0]  w;
    int               n_body;
    cnt = nev;
    size = nev + 2;
    n_body = nev;
    case (flaw)
      FLAW_MISMATCH: begin
        cnt = (nev > 0 && $urandom_range(0, 1) == 1) ? nev - 1 : nev + $urandom_range(1, 4);
      end
      FLAW_BIGCOUNT: begin
        cnt = $urandom_range(16'h7FFE, 16'hFFFF);
        size = cnt + 2;
        n_body = $urandom_range(0, 2);
      end
      FLAW_CUT: n_body = $urandom_range(0, nev - 1);
      FLAW_EXTRA: n_body = nev + $urandom_range(1, 3);
      default: ;
    endcase
    w = {$urandom, $urandom};
    w[50:36] = size;
    w[35:0] = fno;
    send_word(w, 1'b1);
    if (flaw != FLAW_NOCOUNT) begin
      w = {$urandom, $urandom};
      w[15:0] = cnt;
      send_word(w, 1'b0);
      repeat (n_body) send_word(make_event(), 1'b0);
    end
  endtask

  task automatic random_phase(input int n_words);
    int stop_at;
    int r;
    int nev;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      nev = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      if (r < 72) send_frame(pick_frame(), nev, FLAW_NONE);
      else if (r < 78) send_frame(pick_frame(), nev, FLAW_MISMATCH);
      else if (r < 83) send_frame(pick_frame(), nev + 1, FLAW_CUT);
      else if (r < 88) send_frame(pick_frame(), nev, FLAW_EXTRA);
      else if (r < 91) send_frame(pick_frame(), nev, FLAW_BIGCOUNT);
      else if (r < 94) send_frame(pick_frame(), nev, FLAW_NOCOUNT);
      else send_word({$urandom, $urandom}, $urandom_range(0, 9) == 0);
    end
    settle();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    words_sent = 0;
    mask_count = 0;
    idle_on = 1'b1;
    frame_base = {$urandom, $urandom};
    prev_evt = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_mask('0);

    // Directed: empty frame, extreme frame number and event words, and a
    // repeated event on one store entry with one other event between.
    send_frame('0, 0, FLAW_NONE);
    send_word({13'h1FFF, 15'd5, 36'hF_FFFF_FFFF}, 1'b1);
    send_word({47'h7FFF_FFFF_FFFF, 1'b1, 16'd3}, 1'b0);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    // A size below two can never match its count.
    send_word({13'h0, 15'd1, 36'h0_0000_0123}, 1'b1);
    send_word('0, 1'b0);
    send_frame(pick_frame(), 1, FLAW_MISMATCH);
    send_frame(pick_frame(), 0, FLAW_BIGCOUNT);
    send_frame(pick_frame(), 3, FLAW_CUT);
    send_frame(pick_frame(), 1, FLAW_EXTRA);
    send_frame(pick_frame(), 0, FLAW_NOCOUNT);
    send_word({$urandom, $urandom}, 1'b0);
    settle();

    write_mask('1);
    random_phase(PHASE_WORDS);
    write_mask({$urandom});
    random_phase(PHASE_WORDS);
    write_mask(32'h5555_AAAA);
    random_phase(PHASE_WORDS);
    write_mask({$urandom});
    random_phase(PHASE_WORDS);
    idle_on = 1'b0;
    write_mask('0);
    random_phase(PHASE_WORDS);

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.drain_check();
    $display("Drove %0d frame words under %0d format masks.", words_sent, mask_count);
    $display("Checked %0d accepted frames, %0d skipped frames and %0d events.",
             sb.n_accept, sb.n_skip, sb.n_event);
    if (sb.errors == 0) begin
      $display("[event_frame_idle_time_tracker_unit] OK");
    end else begin
      $display("[event_frame_idle_time_tracker_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/efit_pkg.sv
src/efit_ram.sv
src/efit_parse.sv
src/efit_idle.sv
src/event_frame_idle_time_tracker_unit.sv
sim/tb_top.sv
